### sv/hscm_pkg.sv
package hscm_pkg;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_MIN_HUE = 2'd0,
		REG_MAX_HUE = 2'd1,
		REG_MIN_SAT = 2'd2,
		REG_MAX_SAT = 2'd3
	} cfg_reg_t;

	localparam int CfgIdxW  = 2;
	localparam int CfgDataW = 8;

	localparam logic [7:0] MinHueRst = 8'd160;
	localparam logic [7:0] MaxHueRst = 8'd10;
	localparam logic [7:0] MinSatRst = 8'd25;
	localparam logic [7:0] MaxSatRst = 8'd166;

	// fixed point: 12 fraction bits
	localparam int FixShift = 12;
	localparam int SdivW    = 20;
	localparam int HdivW    = 17;
	localparam int HueRange = 180;

	typedef logic [SdivW-1:0] sdiv_tab_t [256];
	typedef logic [HdivW-1:0] hdiv_tab_t [256];

	// shift-subtract division, rounded to nearest with ties to even
	function automatic logic [20:0] recip_round(input logic [31:0] num, input logic [31:0] den);
		logic [32:0] rem;
		logic [31:0] q;
		rem = '0;
		q   = '0;
		for (int i = 31; i >= 0; i--) begin
			rem = {rem[31:0], num[i]};
			if (rem >= {1'b0, den}) begin
				rem  = rem - {1'b0, den};
				q[i] = 1'b1;
			end
		end
		if ({rem[31:0], 1'b0} > {1'b0, den} || ({rem[31:0], 1'b0} == {1'b0, den} && q[0]))
			q = q + 32'd1;
		return q[20:0];
	endfunction

	// saturation reciprocal: 255*4096/v
	function automatic sdiv_tab_t build_sdiv();
		sdiv_tab_t t;
		logic [20:0] r;
		t[0] = '0;
		for (int i = 1; i < 256; i++) begin
			r    = recip_round(32'(255 << FixShift), 32'(i));
			t[i] = r[SdivW-1:0];
		end
		return t;
	endfunction

	// hue reciprocal: 180*4096/(6*d)
	function automatic hdiv_tab_t build_hdiv();
		hdiv_tab_t t;
		logic [20:0] r;
		t[0] = '0;
		for (int i = 1; i < 256; i++) begin
			r    = recip_round(32'(HueRange << FixShift), 32'(6 * i));
			t[i] = r[HdivW-1:0];
		end
		return t;
	endfunction

	localparam sdiv_tab_t SdivTab = build_sdiv();
	localparam hdiv_tab_t HdivTab = build_hdiv();

endpackage

### sv/hscm_if.sv
interface hscm_pix_if;
	logic       valid;
	logic       ready;
	logic [7:0] blue;
	logic [7:0] green;
	logic [7:0] red;

	modport source (output valid, output blue, output green, output red, input ready);
	modport sink (input valid, input blue, input green, input red, output ready);
endinterface

interface hscm_res_if;
	logic       valid;
	logic       ready;
	logic       in_range;
	logic [7:0] out_blue;
	logic [7:0] out_green;
	logic [7:0] out_red;

	modport source (output valid, output in_range, output out_blue, output out_green,
		output out_red, input ready);
	modport sink (input valid, input in_range, input out_blue, input out_green,
		input out_red, output ready);
endinterface

### sv/hsv_skin_color_mask_top.sv
// HSV color-range pixel mask. Each word on pixel is one 8-bit BGR pixel; the
// block converts it to 8-bit HSV (hue 0..179 in half degrees, saturation
// 0..255 via reciprocal tables of 12 fraction bits) and emits one result word: in_range
// is high when min_hue < hue <= max_hue (or, when min_hue >= max_hue, hue > min_hue
// or hue <= max_hue, wrapping through zero) and min_sat < sat <= max_sat; the
// color fields carry the pixel when in range and zero otherwise. The pipeline
// is four register stages deep, stages 1 to 4, and the result word of a pixel
// is driven from the stage 4 registers; one pixel is accepted every cycle while
// the result side keeps ready high. The whole pipeline advances together, so a
// low ready on result while a word waits at the output holds every stage and
// pixel.ready follows it in the same cycle; with the output stage empty the pipe
// keeps moving. Registers are written through cfg_we/cfg_index/cfg_data; the
// user must write them only while the block is idle, as the block itself does
// not enforce it; indexes 0..3 are min_hue, max_hue, min_sat, max_sat.
module hsv_skin_color_mask_top (
	input  logic                         clk,
	input  logic                         arst_n,
	hscm_pix_if.sink                     pixel,
	hscm_res_if.source                   result,
	input  logic                         cfg_we,
	input  logic [hscm_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [hscm_pkg::CfgDataW-1:0] cfg_data
);
	import hscm_pkg::*;

	// configuration registers
	logic [7:0] min_hue_q, max_hue_q, min_sat_q, max_sat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_hue_q <= MinHueRst;
			max_hue_q <= MaxHueRst;
			min_sat_q <= MinSatRst;
			max_sat_q <= MaxSatRst;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_MIN_HUE: min_hue_q <= cfg_data;
				REG_MAX_HUE: max_hue_q <= cfg_data;
				REG_MIN_SAT: min_sat_q <= cfg_data;
				REG_MAX_SAT: max_sat_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// one enable for the whole pipe: move when the output stage is empty or drained
	logic adv;
	logic v_s1, v_s2, v_s3, v_s4;

	assign adv         = !v_s4 || result.ready;
	assign pixel.ready = adv;

	// ---- stage 1: max, min, chroma and the hue numerator
	logic        [7:0]  vmax_c, vmin_c, diff_c;
	logic signed [11:0] num_c;
	logic        [7:0]  blue_s1, green_s1, red_s1, vmax_s1, diff_s1;
	logic signed [11:0] num_s1;

	always_comb begin
		vmax_c = pixel.blue;
		vmin_c = pixel.blue;
		if (pixel.green > vmax_c) vmax_c = pixel.green;
		if (pixel.red > vmax_c)   vmax_c = pixel.red;
		if (pixel.green < vmin_c) vmin_c = pixel.green;
		if (pixel.red < vmin_c)   vmin_c = pixel.red;
		diff_c = vmax_c - vmin_c;
		// ties pick red first, then green
		if (vmax_c == pixel.red)
			num_c = $signed({4'd0, pixel.green}) - $signed({4'd0, pixel.blue});
		else if (vmax_c == pixel.green)
			num_c = $signed({4'd0, pixel.blue}) - $signed({4'd0, pixel.red})
				+ $signed({3'd0, diff_c, 1'b0});
		else
			num_c = $signed({4'd0, pixel.red}) - $signed({4'd0, pixel.green})
				+ $signed({2'd0, diff_c, 2'b0});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= pixel.valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			blue_s1  <= pixel.blue;
			green_s1 <= pixel.green;
			red_s1   <= pixel.red;
			vmax_s1  <= vmax_c;
			diff_s1  <= diff_c;
			num_s1   <= num_c;
		end
	end

	// ---- stage 2: reciprocal table lookups
	logic        [7:0]       blue_s2, green_s2, red_s2, diff_s2;
	logic signed [11:0]      num_s2;
	logic        [SdivW-1:0] sdiv_s2;
	logic        [HdivW-1:0] hdiv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (adv) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			blue_s2  <= blue_s1;
			green_s2 <= green_s1;
			red_s2   <= red_s1;
			diff_s2  <= diff_s1;
			num_s2   <= num_s1;
			sdiv_s2  <= SdivTab[vmax_s1];
			hdiv_s2  <= HdivTab[diff_s1];
		end
	end

	// ---- stage 3: the two multiplies
	logic        [7:0]  blue_s3, green_s3, red_s3;
	logic        [27:0] sprod_s3;
	logic signed [29:0] hprod_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (adv) v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			blue_s3  <= blue_s2;
			green_s3 <= green_s2;
			red_s3   <= red_s2;
			sprod_s3 <= 28'(diff_s2 * sdiv_s2);
			hprod_s3 <= 30'(num_s2 * $signed({1'b0, hdiv_s2}));
		end
	end

	// ---- stage 4: round, wrap hue, range tests, gate the pixel
	logic        [27:0] sround;
	logic signed [29:0] hround;
	logic        [7:0]  sat;
	logic signed [8:0]  hue_raw;
	logic        [8:0]  hue;
	logic               hue_lo, hue_hi, hue_ok, sat_ok, ok;
	logic               in_range_s4;
	logic        [7:0]  blue_s4, green_s4, red_s4;

	always_comb begin
		sround  = sprod_s3 + 28'd2048;
		sat     = sround[19:12];
		// floor shift of the rounded product
		hround  = hprod_s3 + 30'sd2048;
		hue_raw = hround[20:12];
		hue     = hue_raw[8] ? 9'(hue_raw + 9'sd180) : hue_raw;
		hue_lo  = hue > {1'b0, min_hue_q};
		hue_hi  = hue <= {1'b0, max_hue_q};
		// wraparound through zero when the bounds are crossed
		hue_ok  = (min_hue_q < max_hue_q) ? (hue_lo && hue_hi) : (hue_lo || hue_hi);
		sat_ok  = (sat > min_sat_q) && (sat <= max_sat_q);
		ok      = hue_ok && sat_ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (adv) v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			in_range_s4 <= ok;
			blue_s4     <= ok ? blue_s3  : 8'd0;
			green_s4    <= ok ? green_s3 : 8'd0;
			red_s4      <= ok ? red_s3   : 8'd0;
		end
	end

	assign result.valid     = v_s4;
	assign result.in_range  = in_range_s4;
	assign result.out_blue  = blue_s4;
	assign result.out_green = green_s4;
	assign result.out_red   = red_s4;

`ifndef SYNTH
	// a full stage 3 reaches the output on the next advance
	a_adv_moves: assert property (@(posedge clk) disable iff (!arst_n)
		adv && v_s3 |=> v_s4)
		else $error("stage 3 word did not reach the output");

	// a held output word keeps the whole pipe frozen
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && !result.ready |=> v_s4 && $stable(v_s3) && $stable(sprod_s3))
		else $error("pipe moved under a stalled output");

	// an out-of-range word carries a black pixel
	a_gate_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.in_range |->
		result.out_blue == 8'd0 && result.out_green == 8'd0 && result.out_red == 8'd0)
		else $error("masked pixel not zeroed");

	// grey pixels get zero hue numerator contribution once they reach stage 3
	a_grey_hue: assert property (@(posedge clk) disable iff (!arst_n)
		adv && v_s1 && diff_s1 == 8'd0 ##1 adv |=> hprod_s3 == 30'sd0)
		else $error("grey pixel produced nonzero hue product");
`endif

endmodule

### tb/hscm_mask_checker.sv
module hscm_mask_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	hscm_pix_if                           pixel,
	hscm_res_if                           result,
	input  logic                          cfg_we,
	input  logic [hscm_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [hscm_pkg::CfgDataW-1:0] cfg_data,
	input  logic                          closing,
	output int                            pending,
	output int                            errors
);
	import hscm_pkg::*;

	typedef struct packed {
		logic       in_range;
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} mask_word_t;

	// shadow of the bound registers
	logic [7:0] lo_hue, hi_hue, lo_sat, hi_sat;
	mask_word_t mask_due [$];
	logic closed;

	initial errors = 0;

	task automatic report(input string what);
		errors++;
		// keep the log readable when the block is badly broken
		if (errors <= 100)
			$display("%0t: mismatch: %s", $time, what);
	endtask

	// integer division rounded to nearest, ties to even
	function automatic longint div_nearest(input longint num, input longint den);
		longint q, rem;
		q   = num / den;
		rem = num % den;
		if (2 * rem > den || (2 * rem == den && q[0]))
			q++;
		return q;
	endfunction

	function automatic mask_word_t predict_mask(input logic [7:0] b, g, r);
		longint bl, gr, rd, top, bot, diff, num, srecip, hrecip, sat, hue;
		logic hue_ok, sat_ok;
		mask_word_t w;
		bl   = longint'(b);
		gr   = longint'(g);
		rd   = longint'(r);
		top  = bl;
		bot  = bl;
		if (gr > top) top = gr;
		if (rd > top) top = rd;
		if (gr < bot) bot = gr;
		if (rd < bot) bot = rd;
		diff = top - bot;
		srecip = (top == 0) ? 0 : div_nearest(255 * 4096, top);
		sat    = (diff * srecip + 2048) >>> 12;
		// ties: red wins, then green
		if (top == rd)
			num = gr - bl;
		else if (top == gr)
			num = bl - rd + 2 * diff;
		else
			num = rd - gr + 4 * diff;
		hrecip = (diff == 0) ? 0 : div_nearest(180 * 4096, 6 * diff);
		// arithmetic shift floors negative hues
		hue = (num * hrecip + 2048) >>> 12;
		if (hue < 0)
			hue += 180;
		if (lo_hue < hi_hue)
			hue_ok = (hue > longint'(lo_hue)) && (hue <= longint'(hi_hue));
		else
			hue_ok = (hue > longint'(lo_hue)) || (hue <= longint'(hi_hue));
		sat_ok = (sat > longint'(lo_sat)) && (sat <= longint'(hi_sat));
		w.in_range = hue_ok && sat_ok;
		w.blue     = w.in_range ? b : 8'd0;
		w.green    = w.in_range ? g : 8'd0;
		w.red      = w.in_range ? r : 8'd0;
		return w;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		mask_word_t want;
		if (!arst_n) begin
			lo_hue = MinHueRst;
			hi_hue = MaxHueRst;
			lo_sat = MinSatRst;
			hi_sat = MaxSatRst;
			mask_due.delete();
			closed = 1'b0;
			pending <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_MIN_HUE: lo_hue = cfg_data;
					REG_MAX_HUE: hi_hue = cfg_data;
					REG_MIN_SAT: lo_sat = cfg_data;
					REG_MAX_SAT: hi_sat = cfg_data;
				endcase
			end
			if (pixel.valid && pixel.ready)
				mask_due.push_back(predict_mask(pixel.blue, pixel.green, pixel.red));
			if (result.valid && result.ready) begin
				if (mask_due.size() == 0) begin
					report($sformatf("result word with no pixel pending (in_range %0b)",
						result.in_range));
				end else begin
					want = mask_due.pop_front();
					if (result.in_range !== want.in_range)
						report($sformatf("in_range got %0b want %0b",
							result.in_range, want.in_range));
					if (result.out_blue !== want.blue)
						report($sformatf("out_blue got %0d want %0d",
							result.out_blue, want.blue));
					if (result.out_green !== want.green)
						report($sformatf("out_green got %0d want %0d",
							result.out_green, want.green));
					if (result.out_red !== want.red)
						report($sformatf("out_red got %0d want %0d",
							result.out_red, want.red));
				end
			end
			if (closing && !closed) begin
				closed = 1'b1;
				while (mask_due.size() != 0) begin
					want = mask_due.pop_front();
					report($sformatf("no result word for pixel (want in_range %0b)",
						want.in_range));
				end
			end
			pending <= mask_due.size();
		end
	end

endmodule

### tb/tb_top.sv
module tb_top;
	import hscm_pkg::*;

	localparam int PerPhase  = 215;
	localparam int NumPhases = 8;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_we;
	logic [CfgIdxW-1:0]  cfg_index;
	logic [CfgDataW-1:0] cfg_data;
	logic                closing;
	logic                calm;
	int                  pending;
	int                  errors;

	hscm_pix_if pix_if ();
	hscm_res_if res_if ();

	// fixed bound settings: min_hue, max_hue, min_sat, max_sat
	// the last two phases draw theirs at random
	logic [7:0] bound_set [6][4] = '{
		'{8'd0,   8'd180, 8'd0,   8'd255},  // widest plain window
		'{8'd0,   8'd0,   8'd0,   8'd0},    // equal hue bounds wrap to all, empty sat
		'{8'd255, 8'd255, 8'd255, 8'd255},  // top extremes
		'{8'd20,  8'd40,  8'd50,  8'd200},  // narrow plain window
		'{8'd250, 8'd5,   8'd0,   8'd128},  // wrap with min above 180
		'{8'd200, 8'd255, 8'd100, 8'd255}   // plain window above any hue
	};

	// hand-picked pixels, blue/green/red
	logic [7:0] directed_px [22][3] = '{
		'{8'd0,   8'd0,   8'd0},    // black
		'{8'd255, 8'd255, 8'd255},  // white
		'{8'd128, 8'd128, 8'd128},  // grey
		'{8'd0,   8'd0,   8'd255},  // pure red
		'{8'd0,   8'd255, 8'd0},    // pure green
		'{8'd255, 8'd0,   8'd0},    // pure blue
		'{8'd0,   8'd255, 8'd255},  // red/green tie
		'{8'd255, 8'd255, 8'd0},    // green/blue tie
		'{8'd255, 8'd0,   8'd255},  // red/blue tie
		'{8'd120, 8'd150, 8'd220},  // skin tone
		'{8'd50,  8'd0,   8'd255},  // red max, hue goes negative and wraps
		'{8'd1,   8'd0,   8'd255},  // red max, tiny negative hue rounds to 0
		'{8'd0,   8'd0,   8'd1},    // smallest nonzero value
		'{8'd0,   8'd1,   8'd1},
		'{8'd254, 8'd255, 8'd255},  // tiny spread at the top
		'{8'd255, 8'd254, 8'd254},
		'{8'd0,   8'd1,   8'd255},
		'{8'd100, 8'd110, 8'd120},  // low saturation
		'{8'd0,   8'd128, 8'd255},  // orange
		'{8'd40,  8'd60,  8'd90},
		'{8'd1,   8'd0,   8'd0},
		'{8'd128, 8'd0,   8'd128}
	};

	hsv_skin_color_mask_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pixel     (pix_if),
		.result    (res_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	hscm_mask_checker chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.pixel     (pix_if),
		.result    (res_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.closing   (closing),
		.pending   (pending),
		.errors    (errors)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// hold a pixel word on the channel until it is taken
	task automatic push_pixel(input logic [7:0] b, g, r);
		pix_if.valid <= 1'b1;
		pix_if.blue  <= b;
		pix_if.green <= g;
		pix_if.red   <= r;
		do @(posedge clk); while (!pix_if.ready);
	endtask

	// random burst of source idling, none once the run goes calm
	task automatic idle_gap();
		if (!calm && $urandom_range(0, 7) == 0) begin
			pix_if.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	// drop valid, let every expected word drain, then cover the pipeline depth
	task automatic settle();
		pix_if.valid <= 1'b0;
		@(posedge clk);
		for (int n = 0; n < 4000 && pending != 0; n++)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	// one register per cycle, enable held high across the burst
	task automatic set_bounds(input logic [7:0] vals [4]);
		for (int k = 0; k < 4; k++) begin
			cfg_we    <= 1'b1;
			cfg_index <= cfg_reg_t'(k);
			cfg_data  <= vals[k];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	function automatic logic [7:0] extreme_level();
		case ($urandom_range(0, 4))
			0: return 8'd0;
			1: return 8'd1;
			2: return 8'd254;
			3: return 8'd255;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// mostly uniform pixels, plus skin-like, near-grey and extreme ones
	task automatic pick_pixel(output logic [7:0] b, g, r);
		int base;
		case ($urandom_range(0, 9))
			6, 7: begin
				r = 8'($urandom_range(100, 255));
				g = 8'($urandom_range(30, r));
				b = 8'($urandom_range(0, g));
			end
			8: begin
				base = $urandom_range(0, 255);
				b = 8'((base + 3 > 255) ? 255 : base + $urandom_range(0, 3));
				g = 8'((base < 3) ? 0 : base - $urandom_range(0, 3));
				r = 8'(base);
			end
			9: begin
				b = extreme_level();
				g = extreme_level();
				r = extreme_level();
			end
			default: begin
				b = 8'($urandom_range(0, 255));
				g = 8'($urandom_range(0, 255));
				r = 8'($urandom_range(0, 255));
			end
		endcase
	endtask

	// result side: random stalls, long open stretches, always open when calm
	initial begin
		res_if.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (calm) begin
				res_if.ready <= 1'b1;
				@(posedge clk);
			end else begin
				case ($urandom_range(0, 9))
					0, 1: begin
						res_if.ready <= 1'b0;
						repeat ($urandom_range(1, 12)) @(posedge clk);
					end
					2: begin
						res_if.ready <= 1'b1;
						repeat ($urandom_range(40, 150)) @(posedge clk);
					end
					default: begin
						res_if.ready <= 1'b1;
						repeat ($urandom_range(1, 10)) @(posedge clk);
					end
				endcase
			end
		end
	end

	// stimulus and verdict
	initial begin
		logic [7:0] b, g, r;
		logic [7:0] bounds [4];
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = REG_MIN_HUE;
		cfg_data     = '0;
		closing      = 1'b0;
		calm         = 1'b0;
		pix_if.valid = 1'b0;
		pix_if.blue  = '0;
		pix_if.green = '0;
		pix_if.red   = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset bounds: wrap through zero on hue
		foreach (directed_px[i]) begin
			idle_gap();
			push_pixel(directed_px[i][0], directed_px[i][1], directed_px[i][2]);
		end
		repeat (PerPhase) begin
			pick_pixel(b, g, r);
			idle_gap();
			push_pixel(b, g, r);
		end

		for (int p = 0; p < NumPhases; p++) begin
			settle();
			if (p < 6)
				bounds = bound_set[p];
			else
				foreach (bounds[k])
					bounds[k] = 8'($urandom_range(0, 255));
			set_bounds(bounds);
			// last phase runs with no idling on either side
			calm = (p == NumPhases - 1);
			repeat (PerPhase) begin
				pick_pixel(b, g, r);
				idle_gap();
				push_pixel(b, g, r);
			end
		end

		settle();
		closing <= 1'b1;
		repeat (2) @(posedge clk);
		if (errors == 0)
			$display("** hsv_skin_color_mask_top: PASSED **");
		else
			$display("** hsv_skin_color_mask_top: FAILED **");
		$finish;
	end

	// hang guard, far beyond the slowest legal run
	initial begin
		#8000000;
		$display("** hsv_skin_color_mask_top: FAILED **");
		$finish;
	end

endmodule
